@@ hdl/erdc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and register map for the entrance relay door controller.
// No dependencies; erdc_cfg, erdc_ctrl, the top level and the testbench import this package.
package erdc_pkg;

	// Default counter widths
	localparam int ERDC_TIMER_BITS = 24;
	localparam int ERDC_PULSE_BITS = 16;

	// Configuration port geometry
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 24;
	localparam int TICK_REG_BITS  = 24;
	localparam int PULSE_REG_BITS = 16;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_AUTO_CLOSE_ENABLE = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TRAVEL_TICKS      = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AUTO_CLOSE_TICKS  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_TICKS       = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_REPORT_PERIOD     = 3'd4;

	// Register reset values
	localparam logic                      RST_AUTO_CLOSE_ENABLE = 1'b1;
	localparam logic [TICK_REG_BITS-1:0]  RST_TRAVEL_TICKS      = 24'd15000;
	localparam logic [TICK_REG_BITS-1:0]  RST_AUTO_CLOSE_TICKS  = 24'd60000;
	localparam logic [PULSE_REG_BITS-1:0] RST_PULSE_TICKS       = 16'd500;
	localparam logic [TICK_REG_BITS-1:0]  RST_REPORT_PERIOD     = 24'd30000;

	typedef enum logic [1:0] {
		DOOR_CLOSED = 2'd0,
		DOOR_MOVING = 2'd1,
		DOOR_HOLD   = 2'd2,
		DOOR_MOM    = 2'd3
	} door_t;

	typedef enum logic [1:0] {
		CMD_TOGGLE = 2'd0,
		CMD_MOM    = 2'd1,
		CMD_CLOSE  = 2'd2,
		CMD_HOLD   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic                      auto_close_enable;
		logic [TICK_REG_BITS-1:0]  travel_ticks;
		logic [TICK_REG_BITS-1:0]  auto_close_ticks;
		logic [PULSE_REG_BITS-1:0] pulse_ticks;
		logic [TICK_REG_BITS-1:0]  report_period;
	} cfg_t;

	typedef struct packed {
		logic op;
		cmd_t command;
	} item_t;

	typedef struct packed {
		logic  relay_on;
		door_t door_now;
		door_t door_pending;
		logic  report_due;
	} result_t;

endpackage

@@ hdl/erdc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the door controller: input items and results.
// No dependencies.
interface erdc_item_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [1:0] command;

	modport source (output valid, output op, output command, input ready);
	modport sink (input valid, input op, input command, output ready);
endinterface

interface erdc_result_if;
	logic       valid;
	logic       ready;
	logic       relay_on;
	logic [1:0] door_now;
	logic [1:0] door_pending;
	logic       report_due;

	modport source (output valid, output relay_on, output door_now, output door_pending,
		output report_due, input ready);
	modport sink (input valid, input relay_on, input door_now, input door_pending,
		input report_due, output ready);
endinterface

@@ hdl/erdc_cfg.sv @@
`timescale 1ns / 1ps
// Configuration register bank of the door controller.
// Depends on erdc_pkg for the register map, reset values and cfg_t.
module erdc_cfg
	import erdc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// Write the addressed register; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_close_enable <= RST_AUTO_CLOSE_ENABLE;
			cfg_q.travel_ticks      <= RST_TRAVEL_TICKS;
			cfg_q.auto_close_ticks  <= RST_AUTO_CLOSE_TICKS;
			cfg_q.pulse_ticks       <= RST_PULSE_TICKS;
			cfg_q.report_period     <= RST_REPORT_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AUTO_CLOSE_ENABLE: cfg_q.auto_close_enable <= cfg_data[0];
				REG_TRAVEL_TICKS:      cfg_q.travel_ticks <= TICK_REG_BITS'(cfg_data);
				REG_AUTO_CLOSE_TICKS:  cfg_q.auto_close_ticks <= TICK_REG_BITS'(cfg_data);
				REG_PULSE_TICKS:       cfg_q.pulse_ticks <= cfg_data[PULSE_REG_BITS-1:0];
				REG_REPORT_PERIOD:     cfg_q.report_period <= TICK_REG_BITS'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/erdc_ctrl.sv @@
`timescale 1ns / 1ps
// Door state machine, relay pulse timer, transition countdown and keepalive counter.
// Depends on erdc_pkg; advances by one transaction whenever step is high.
module erdc_ctrl
	import erdc_pkg::*;
#(
	parameter int TIMER_BITS = ERDC_TIMER_BITS,
	parameter int PULSE_BITS = ERDC_PULSE_BITS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	door_t                 door_q, door_d;
	door_t                 next_q, next_d;
	logic [TIMER_BITS-1:0] tc_q, tc_d;
	logic                  relay_q, relay_d;
	logic [PULSE_BITS-1:0] pulse_q, pulse_d;
	logic [TIMER_BITS-1:0] rpt_q, rpt_d;
	logic                  rpt_hit;

	logic [TIMER_BITS-1:0] mov_ticks;
	logic [TIMER_BITS-1:0] acl_ticks;
	logic [TIMER_BITS-1:0] per_ticks;
	logic [PULSE_BITS-1:0] pls_ticks;
	logic                  ace;
	cmd_t                  cmd;

	// Bring register values to counter width
	assign mov_ticks = TIMER_BITS'(cfg.travel_ticks);
	assign acl_ticks = TIMER_BITS'(cfg.auto_close_ticks);
	assign per_ticks = TIMER_BITS'(cfg.report_period);
	assign pls_ticks = PULSE_BITS'(cfg.pulse_ticks);
	assign ace       = cfg.auto_close_enable;
	assign cmd       = item.command;

	// Next state: a command acts on the door, a tick advances all timers
	always_comb begin
		door_d  = door_q;
		next_d  = next_q;
		tc_d    = tc_q;
		relay_d = relay_q;
		pulse_d = pulse_q;
		rpt_d   = rpt_q;
		rpt_hit = 1'b0;
		if (item.op) begin
			unique case (door_q)
				DOOR_CLOSED: begin
					if (cmd == CMD_TOGGLE || cmd == CMD_MOM) begin
						relay_d = 1'b1;
						pulse_d = pls_ticks;
						door_d  = DOOR_MOVING;
						next_d  = ace ? DOOR_MOM : DOOR_HOLD;
						tc_d    = mov_ticks;
					end else if (cmd == CMD_HOLD) begin
						relay_d = 1'b1;
						pulse_d = ace ? '0 : pls_ticks;
						door_d  = DOOR_MOVING;
						next_d  = DOOR_HOLD;
						tc_d    = mov_ticks;
					end
				end
				DOOR_HOLD: begin
					if (cmd == CMD_TOGGLE || cmd == CMD_CLOSE) begin
						relay_d = 1'b1;
						pulse_d = pls_ticks;
						door_d  = DOOR_MOVING;
						next_d  = DOOR_CLOSED;
						tc_d    = mov_ticks;
					end else if (cmd == CMD_MOM && ace) begin
						relay_d = 1'b0;
						pulse_d = '0;
						door_d  = DOOR_MOM;
						next_d  = DOOR_MOVING;
						tc_d    = acl_ticks;
					end
				end
				DOOR_MOM: begin
					if (cmd == CMD_TOGGLE || cmd == CMD_CLOSE) begin
						relay_d = 1'b1;
						pulse_d = pls_ticks;
						door_d  = DOOR_MOVING;
						next_d  = DOOR_CLOSED;
						tc_d    = mov_ticks;
					end else if (cmd == CMD_HOLD && ace) begin
						// hold open drops the scheduled auto close
						relay_d = 1'b1;
						pulse_d = '0;
						door_d  = DOOR_HOLD;
						next_d  = DOOR_HOLD;
						tc_d    = '0;
					end
				end
				DOOR_MOVING: begin
					// commands are ignored while the door travels
				end
			endcase
		end else begin
			// count the relay pulse down and release at its end
			if (pulse_q != '0) begin
				pulse_d = pulse_q - PULSE_BITS'(1);
				if (pulse_q == PULSE_BITS'(1))
					relay_d = 1'b0;
			end
			// run the timed transition while one is scheduled
			if (door_q != next_q) begin
				if (tc_q <= TIMER_BITS'(1)) begin
					door_d = next_q;
					tc_d   = '0;
					if (next_q == DOOR_MOVING) begin
						tc_d = mov_ticks;
						if (door_q == DOOR_CLOSED)
							next_d = DOOR_HOLD;
						else if (door_q == DOOR_MOM || door_q == DOOR_HOLD)
							next_d = DOOR_CLOSED;
					end else if (next_q == DOOR_MOM && ace) begin
						tc_d   = acl_ticks;
						next_d = DOOR_MOVING;
					end
				end else begin
					tc_d = tc_q - TIMER_BITS'(1);
				end
			end
			// keepalive report
			if (rpt_q <= TIMER_BITS'(1)) begin
				rpt_hit = 1'b1;
				rpt_d   = per_ticks;
			end else begin
				rpt_d = rpt_q - TIMER_BITS'(1);
			end
		end
		// any change of door state is reported and restarts the keepalive
		if (door_d != door_q) begin
			rpt_hit = 1'b1;
			rpt_d   = per_ticks;
		end
	end

	// Result of the transaction in flight
	always_comb begin
		res.relay_on     = relay_d;
		res.door_now     = door_d;
		res.door_pending = next_d;
		res.report_due   = rpt_hit;
	end

	// Hold state between transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			door_q  <= DOOR_CLOSED;
			next_q  <= DOOR_CLOSED;
			tc_q    <= '0;
			relay_q <= 1'b0;
			pulse_q <= '0;
			rpt_q   <= '0;
		end else if (step) begin
			door_q  <= door_d;
			next_q  <= next_d;
			tc_q    <= tc_d;
			relay_q <= relay_d;
			pulse_q <= pulse_d;
			rpt_q   <= rpt_d;
		end
	end

	// A running pulse implies the relay is driven
	a_pulse_relay: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_q != '0 |-> relay_q)
		else $error("relay pulse running with relay off");

	// Travel always has a destination other than travel
	a_moving_target: assert property (@(posedge clk) disable iff (!arst_n)
		door_q == DOOR_MOVING |-> next_q != DOOR_MOVING)
		else $error("door moving towards moving");

	// No countdown left over when nothing is scheduled
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		door_q == next_q |-> tc_q == '0)
		else $error("transition count non-zero with nothing scheduled");

endmodule

@@ hdl/entrance_relay_door_controller.sv @@
`timescale 1ns / 1ps
// Top level of the entrance relay door controller: input stage, state logic, result stage.
// Depends on erdc_pkg, erdc_if, erdc_cfg and erdc_ctrl.
//
// Usage:
//   item   - valid/ready channel of transactions: op 0 is one 1 ms tick, op 1 a door
//            command (toggle, momentary open, close, hold open).
//   result - valid/ready channel, exactly one transaction per item: relay level,
//            door state, scheduled next state and the report flag.
//   cfg_*  - register write port (enable, index, data); write only while idle.
// An accepted item sits in the input register, goes through the state update and lands
// in the result register when it moves on, and its result is then offered on result.
// Throughput is one item per cycle while the receiver takes every result; the state
// registers are loaded from the combinational state update of the item they hold.
// If the receiver stalls, the result is held and one more item may wait in the input
// register; item.ready then drops until the result is taken.
// Reset clears both stages, puts the door at closed with no pulse running and loads
// the register defaults; the first tick after reset raises a keepalive report.
module entrance_relay_door_controller
	import erdc_pkg::*;
#(
	parameter int TIMER_BITS = ERDC_TIMER_BITS,
	parameter int PULSE_BITS = ERDC_PULSE_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	erdc_item_if.sink                 item,
	erdc_result_if.source             result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	result_t res;
	logic    advance;
	logic    take;

	erdc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	erdc_ctrl #(
		.TIMER_BITS (TIMER_BITS),
		.PULSE_BITS (PULSE_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Move the held item on when the result register is free or being emptied
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op      <= item.op;
			item_s1.command <= cmd_t'(item.command);
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= res;
	end

	assign result.valid        = valid_s2;
	assign result.relay_on     = result_s2.relay_on;
	assign result.door_now     = result_s2.door_now;
	assign result.door_pending = result_s2.door_pending;
	assign result.report_due   = result_s2.report_due;

	// An empty result stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> item.ready)
		else $error("input stalled with result stage empty");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the entrance relay door controller: directed and random
// transactions checked against a cycle-free door/relay/keepalive predictor.
// Depends on erdc_pkg, erdc_if and entrance_relay_door_controller.
module testbench;
	import erdc_pkg::*;

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_COMMAND = 1'b1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd5;

	localparam int RANDOM_ITEMS    = 1450;
	localparam int RANDOM_PHASES   = 8;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int CYCLE_LIMIT     = 100000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	erdc_item_if   item_ch ();
	erdc_result_if result_ch ();

	entrance_relay_door_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor registers and door state
	logic                       cfg_auto_close;
	logic [TICK_REG_BITS-1:0]   cfg_move;
	logic [TICK_REG_BITS-1:0]   cfg_dwell;
	logic [PULSE_REG_BITS-1:0]  cfg_pulse;
	logic [TICK_REG_BITS-1:0]   cfg_period;
	door_t                      door_pos;
	door_t                      door_goal;
	logic [ERDC_TIMER_BITS-1:0] travel_cnt;
	logic                       relay_lvl;
	logic [ERDC_PULSE_BITS-1:0] pulse_left;
	logic [ERDC_TIMER_BITS-1:0] keepalive_cnt;

	result_t expected_status_q[$];

	int  fail_count       = 0;
	int  items_sent       = 0;
	int  results_checked  = 0;
	int  settings_applied = 0;
	int  cycle_count      = 0;
	logic no_idle         = 1'b0;
	logic [3:0] hold_asked = '0;
	logic [3:0] hold_seen  = '0;
	int  hold_left         = 0;

	// Clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, expected_status_q.size());
			$display("[entrance_relay_door_controller] ERROR");
			$finish;
		end
	end

	// Result receiver: random stalls, long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_OFF_CYCLES;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= no_idle || ($urandom_range(0, 99) >= 30);
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_status_q.size() == 0) begin
				$error("result transaction with no prediction waiting");
				fail_count++;
			end else begin
				want = expected_status_q.pop_front();
				results_checked++;
				if (result_ch.relay_on !== want.relay_on) begin
					$error("relay_on: expected %0d, got %0d", want.relay_on,
						result_ch.relay_on);
					fail_count++;
				end
				if (result_ch.door_now !== want.door_now) begin
					$error("door_now: expected %0d, got %0d", want.door_now,
						result_ch.door_now);
					fail_count++;
				end
				if (result_ch.door_pending !== want.door_pending) begin
					$error("door_pending: expected %0d, got %0d", want.door_pending,
						result_ch.door_pending);
					fail_count++;
				end
				if (result_ch.report_due !== want.report_due) begin
					$error("report_due: expected %0d, got %0d", want.report_due,
						result_ch.report_due);
					fail_count++;
				end
			end
		end
	end

	function automatic void drive_relay(logic [ERDC_PULSE_BITS-1:0] len);
		relay_lvl = 1'b1;
		pulse_left = len;
	endfunction

	function automatic void begin_travel(door_t target);
		door_pos = DOOR_MOVING;
		door_goal = target;
		travel_cnt = cfg_move;
	endfunction

	// Advance the door by one transaction and return the status it should report
	function automatic result_t predict_door_step(logic op, cmd_t cmd);
		door_t   from_pos;
		door_t   prior;
		logic    report;
		result_t r;
		prior = door_pos;
		report = 1'b0;
		if (op == OP_COMMAND) begin
			case (door_pos)
				DOOR_CLOSED: begin
					if (cmd == CMD_TOGGLE || cmd == CMD_MOM) begin
						drive_relay(cfg_pulse);
						begin_travel(cfg_auto_close ? DOOR_MOM : DOOR_HOLD);
					end else if (cmd == CMD_HOLD) begin
						drive_relay(cfg_auto_close ? '0 : cfg_pulse);
						begin_travel(DOOR_HOLD);
					end
				end
				DOOR_HOLD, DOOR_MOM: begin
					if (cmd == CMD_TOGGLE || cmd == CMD_CLOSE) begin
						drive_relay(cfg_pulse);
						begin_travel(DOOR_CLOSED);
					end else if (door_pos == DOOR_HOLD && cmd == CMD_MOM && cfg_auto_close) begin
						// release cancels any running pulse
						relay_lvl = 1'b0;
						pulse_left = '0;
						door_pos = DOOR_MOM;
						door_goal = DOOR_MOVING;
						travel_cnt = cfg_dwell;
					end else if (door_pos == DOOR_MOM && cmd == CMD_HOLD && cfg_auto_close) begin
						drive_relay('0);
						door_pos = DOOR_HOLD;
						door_goal = DOOR_HOLD;
						travel_cnt = '0;
					end
				end
				default: begin
					// commands while moving are dropped
				end
			endcase
		end else begin
			if (pulse_left != 0) begin
				pulse_left = pulse_left - 1'b1;
				if (pulse_left == 0)
					relay_lvl = 1'b0;
			end
			// timed transition fires on a count of one or zero
			if (door_pos != door_goal) begin
				if (travel_cnt <= 1) begin
					from_pos = door_pos;
					door_pos = door_goal;
					travel_cnt = '0;
					if (door_pos == DOOR_MOVING) begin
						travel_cnt = cfg_move;
						if (from_pos == DOOR_CLOSED)
							door_goal = DOOR_HOLD;
						else if (from_pos == DOOR_MOM || from_pos == DOOR_HOLD)
							door_goal = DOOR_CLOSED;
					end else if (door_pos == DOOR_MOM && cfg_auto_close) begin
						travel_cnt = cfg_dwell;
						door_goal = DOOR_MOVING;
					end
				end else begin
					travel_cnt = travel_cnt - 1'b1;
				end
			end
			if (keepalive_cnt <= 1) begin
				report = 1'b1;
				keepalive_cnt = cfg_period;
			end else begin
				keepalive_cnt = keepalive_cnt - 1'b1;
			end
		end
		if (door_pos != prior) begin
			report = 1'b1;
			keepalive_cnt = cfg_period;
		end
		r.relay_on = relay_lvl;
		r.door_now = door_pos;
		r.door_pending = door_goal;
		r.report_due = report;
		return r;
	endfunction

	// Offer one transaction, with an occasional gap first, and predict it once taken
	task automatic send_item(logic op, cmd_t cmd);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(0, 99) < 30)
			gap = $urandom_range(1, 2);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.op <= op;
		item_ch.command <= cmd;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		expected_status_q.push_back(predict_door_step(op, cmd));
		items_sent++;
	endtask

	// Stop offering and wait for every outstanding result
	task automatic settle_idle();
		item_ch.valid <= 1'b0;
		while (expected_status_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_AUTO_CLOSE_ENABLE: cfg_auto_close = data[0];
			REG_TRAVEL_TICKS:      cfg_move = data[TICK_REG_BITS-1:0];
			REG_AUTO_CLOSE_TICKS:  cfg_dwell = data[TICK_REG_BITS-1:0];
			REG_PULSE_TICKS:       cfg_pulse = data[PULSE_REG_BITS-1:0];
			REG_REPORT_PERIOD:     cfg_period = data[TICK_REG_BITS-1:0];
			default: begin
				// unknown index: nothing changes
			end
		endcase
	endtask

	// Write all five registers; junk in the unused upper bits must be masked off
	task automatic apply_settings(logic ac, logic [TICK_REG_BITS-1:0] mv,
		logic [TICK_REG_BITS-1:0] dw, logic [PULSE_REG_BITS-1:0] pl,
		logic [TICK_REG_BITS-1:0] rp);
		logic [CFG_DATA_BITS-1:0] junk;
		junk = CFG_DATA_BITS'($urandom);
		cfg_write(REG_AUTO_CLOSE_ENABLE, {junk[CFG_DATA_BITS-1:1], ac});
		cfg_write(REG_TRAVEL_TICKS, mv);
		cfg_write(REG_AUTO_CLOSE_TICKS, dw);
		cfg_write(REG_PULSE_TICKS, {junk[CFG_DATA_BITS-PULSE_REG_BITS-1:0], pl});
		cfg_write(REG_REPORT_PERIOD, rp);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_applied++;
	endtask

	// Defaults: first tick reports, close at a closed door is dropped
	task automatic test_after_reset();
		send_item(OP_TICK, CMD_HOLD);
		send_item(OP_TICK, CMD_TOGGLE);
		send_item(OP_COMMAND, CMD_CLOSE);
		settle_idle();
	endtask

	// Full cycle through every door state with short timers
	task automatic test_door_cycle();
		apply_settings(1'b1, 24'd2, 24'd1, 16'd2, 24'd3);
		send_item(OP_COMMAND, CMD_TOGGLE);
		send_item(OP_COMMAND, CMD_MOM);
		send_item(OP_TICK, CMD_CLOSE);
		send_item(OP_TICK, CMD_MOM);
		send_item(OP_COMMAND, CMD_HOLD);
		send_item(OP_COMMAND, CMD_MOM);
		send_item(OP_TICK, CMD_TOGGLE);
		send_item(OP_TICK, CMD_HOLD);
		send_item(OP_TICK, CMD_TOGGLE);
		settle_idle();
	endtask

	// Zero delays fire on the next tick; pulse length zero holds the relay on
	task automatic test_zero_delays();
		apply_settings(1'b0, 24'd0, 24'd0, 16'd0, 24'd1);
		send_item(OP_COMMAND, CMD_HOLD);
		send_item(OP_TICK, CMD_MOM);
		send_item(OP_COMMAND, CMD_MOM);
		send_item(OP_COMMAND, CMD_TOGGLE);
		send_item(OP_TICK, CMD_CLOSE);
		settle_idle();
	endtask

	// Largest auto-close, pulse and report values with a travel of one, plus a write to an unused index
	task automatic test_register_extremes();
		cfg_write(REG_SPARE, '1);
		apply_settings(1'b1, 24'd1, '1, '1, '1);
		send_item(OP_COMMAND, CMD_TOGGLE);
		send_item(OP_TICK, CMD_TOGGLE);
		send_item(OP_TICK, CMD_HOLD);
		send_item(OP_COMMAND, CMD_CLOSE);
		send_item(OP_TICK, CMD_MOM);
		settle_idle();
	endtask

	// Random commands and ticks across several register settings
	task automatic test_random_traffic();
		int phase;
		int k;
		int per_phase;
		logic op;
		cmd_t cmd;
		logic [PULSE_REG_BITS-1:0] pl;
		logic [TICK_REG_BITS-1:0]  rp;
		per_phase = RANDOM_ITEMS / RANDOM_PHASES;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle_idle();
			case ($urandom_range(0, 5))
				0:       pl = '0;
				1:       pl = '1;
				default: pl = PULSE_REG_BITS'($urandom_range(1, 5));
			endcase
			rp = ($urandom_range(0, 7) == 0) ? '1 : TICK_REG_BITS'($urandom_range(1, 8));
			apply_settings(1'(phase % 2), TICK_REG_BITS'($urandom_range(0, 6)),
				TICK_REG_BITS'($urandom_range(0, 8)), pl, rp);
			no_idle <= (phase == 2);
			for (k = 0; k < per_phase; k++) begin
				// long receiver hold-off while items keep coming
				if (phase == 4 && k == 40)
					hold_asked <= hold_asked + 1'b1;
				// pause until every result is back
				if (phase == 5 && k == 90)
					settle_idle();
				op = ($urandom_range(0, 99) < 30) ? OP_COMMAND : OP_TICK;
				cmd = cmd_t'($urandom_range(0, 3));
				send_item(op, cmd);
			end
		end
		no_idle <= 1'b0;
		settle_idle();
	endtask

	// Maximum travel time: the door stays moving and drops commands
	task automatic test_long_travel();
		apply_settings(1'b0, '1, 24'd4, 16'd3, 24'd2);
		send_item(OP_COMMAND, CMD_TOGGLE);
		send_item(OP_TICK, CMD_CLOSE);
		send_item(OP_COMMAND, CMD_HOLD);
		send_item(OP_TICK, CMD_MOM);
		settle_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.op = 1'b0;
		item_ch.command = '0;

		// predictor reset state
		cfg_auto_close = RST_AUTO_CLOSE_ENABLE;
		cfg_move = RST_TRAVEL_TICKS;
		cfg_dwell = RST_AUTO_CLOSE_TICKS;
		cfg_pulse = RST_PULSE_TICKS;
		cfg_period = RST_REPORT_PERIOD;
		door_pos = DOOR_CLOSED;
		door_goal = DOOR_CLOSED;
		travel_cnt = '0;
		relay_lvl = 1'b0;
		pulse_left = '0;
		keepalive_cnt = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_door_cycle();
		test_zero_delays();
		test_register_extremes();
		test_random_traffic();
		test_long_travel();

		$display("Sent %0d transactions over %0d register settings; %0d results checked.",
			items_sent, settings_applied, results_checked);
		$display("Mismatches: %0d", fail_count);
		if (fail_count == 0)
			$display("[entrance_relay_door_controller] OK");
		else
			$display("[entrance_relay_door_controller] ERROR");
		$finish;
	end

endmodule
